@@ rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared types and codes for the sleep and wakeup timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int unsigned WAKE_W      = 64;
  localparam int unsigned PRIO_W      = 6;
  localparam int unsigned OWNER_W     = 8;
  localparam int unsigned TICKS_W     = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = 4;

  localparam logic CMD_SLEEP = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [WAKE_W-1:0]  wake;
    logic [PRIO_W-1:0]  prio;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/stq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// One slot of the sorted chain. It compares a new entry against its own,
// takes the new entry, its lower neighbor or keeps its own on an insert, and
// takes its upper neighbor on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire stq_pkg::cell_ctl_t ctl,
  input  wire stq_pkg::entry_t    new_ent,
  input  wire stq_pkg::entry_t    prev_ent,
  input  wire                     prev_ins,
  input  wire stq_pkg::entry_t    next_ent,
  output stq_pkg::entry_t         ent,
  output logic                    ins
);

  stq_pkg::entry_t ent_r;
  stq_pkg::entry_t ent_nxt;
  logic            goes_before;

  always_comb begin
    if (new_ent.wake == ent_r.wake) begin
      goes_before = new_ent.prio > ent_r.prio;
    end else begin
      goes_before = $signed(new_ent.wake) < $signed(ent_r.wake);
    end
    ins = !ent_r.valid || goes_before;
  end

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.insert) begin
      if (ins && !prev_ins) begin
        ent_nxt       = new_ent;
        ent_nxt.valid = 1'b1;
      end else if (ins) begin
        ent_nxt = prev_ent;
      end
    end else if (ctl.pop) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

@@ rtl/sleep_wakeup_timer_queue_core.sv @@
// ----------------------------------------------------------------------------
// Sleep and wakeup timer queue
// A tick counter and a chain of cells that holds sleepers sorted by wake
// time, then priority, then arrival.
//
// Channel   Handshake            Payload
// input     start / busy         in_command, in_sleeper_id,
//                                in_sleeper_priority, in_sleep_ticks
// result    out_valid (strobe)   out_result_kind, out_woken_id,
//                                out_wake_tick, out_last
//
// For a sleep request the wake time is added in the transfer cycle and the
// chain inserts in the next one. A tick wakes at most 16 sleepers, one pop
// of the chain per cycle.
// Reset clears the counter and every cell at once; no clearing pass.
// Results are shown for one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module sleep_wakeup_timer_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  in_command,
  input  wire  [stq_pkg::OWNER_W-1:0]          in_sleeper_id,
  input  wire  [stq_pkg::PRIO_W-1:0]           in_sleeper_priority,
  input  wire  signed [stq_pkg::TICKS_W-1:0]   in_sleep_ticks,
  output logic                                 out_valid,
  output logic [stq_pkg::KIND_W-1:0]           out_result_kind,
  output logic [stq_pkg::OWNER_W-1:0]          out_woken_id,
  output logic signed [stq_pkg::WAKE_W-1:0]    out_wake_tick,
  output logic                                 out_last
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_INSERT = 3'b010,
    S_WAKE   = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  logic [stq_pkg::WAKE_W-1:0]       tick_r, tick_nxt;
  logic [stq_pkg::RES_CNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  stq_pkg::entry_t                  new_r;
  logic                             out_valid_r, out_valid_nxt;
  logic [stq_pkg::KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [stq_pkg::OWNER_W-1:0]      out_id_r, out_id_nxt;
  logic [stq_pkg::WAKE_W-1:0]       out_wake_r, out_wake_nxt;
  logic                             out_last_r, out_last_nxt;

  stq_pkg::entry_t                  ent [QUEUE_DEPTH];
  logic                             ins [QUEUE_DEPTH];
  stq_pkg::cell_ctl_t               ctl;
  logic                             accept;
  logic                             full;
  logic                             front_due;
  logic                             second_due;
  logic                             final_res;

  assign accept     = start && (state_r == S_IDLE);
  assign full       = ent[QUEUE_DEPTH-1].valid;
  assign front_due  = ent[0].valid && !($signed(tick_r) < $signed(ent[0].wake));
  assign second_due = ent[1].valid && !($signed(tick_r) < $signed(ent[1].wake));
  assign final_res  = !second_due ||
                      (res_cnt_r == stq_pkg::RES_CNT_W'(stq_pkg::MAX_RESULTS - 1));

  assign ctl.insert = (state_r == S_INSERT) && !full;
  assign ctl.pop    = (state_r == S_WAKE) && front_due;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    stq_pkg::entry_t prev_ent;
    stq_pkg::entry_t next_ent;
    logic            prev_ins;

    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_ins = 1'b0;
    end else begin : g_body
      assign prev_ent = ent[i-1];
      assign prev_ins = ins[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end

    stq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_ent  (new_r),
      .prev_ent (prev_ent),
      .prev_ins (prev_ins),
      .next_ent (next_ent),
      .ent      (ent[i]),
      .ins      (ins[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_wake_nxt  = out_wake_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == stq_pkg::CMD_TICK) begin
            tick_nxt    = tick_r + stq_pkg::WAKE_W'(1);
            res_cnt_nxt = '0;
            state_nxt   = S_WAKE;
          end else begin
            state_nxt = S_INSERT;
          end
        end
      end
      S_INSERT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = full ? stq_pkg::KIND_FULL : stq_pkg::KIND_ACCEPTED;
        out_id_nxt    = new_r.owner;
        out_wake_nxt  = new_r.wake;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_WAKE: begin
        if (front_due) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = stq_pkg::KIND_WOKEN;
          out_id_nxt    = ent[0].owner;
          out_wake_nxt  = ent[0].wake;
          out_last_nxt  = final_res;
          res_cnt_nxt   = res_cnt_r + stq_pkg::RES_CNT_W'(1);
          if (final_res) begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_wake_r <= out_wake_nxt;
    out_last_r <= out_last_nxt;
    if (accept) begin
      new_r.valid <= 1'b1;
      new_r.wake  <= tick_r + {{(stq_pkg::WAKE_W - stq_pkg::TICKS_W){in_sleep_ticks[
                     stq_pkg::TICKS_W-1]}}, in_sleep_ticks};
      new_r.prio  <= in_sleeper_priority;
      new_r.owner <= in_sleeper_id;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_woken_id    = out_id_r;
  assign out_wake_tick   = $signed(out_wake_r);
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

@@ rtl/stq_props.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue port properties
// Checks on the ports of the timer queue over time, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_props (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         start,
  input wire                         busy,
  input wire                         in_command,
  input wire                         out_valid,
  input wire [stq_pkg::KIND_W-1:0]   out_result_kind,
  input wire                         out_last
);

  a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == !busy))
    else $error("Busy does not match the final result of a transfer.");

  a_sleep_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == stq_pkg::CMD_SLEEP)) |-> ##2
      (out_valid && out_last && (out_result_kind != stq_pkg::KIND_WOKEN)))
    else $error("A sleep transfer did not get its answer two cycles later.");

  a_wake_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_valid && (out_result_kind == stq_pkg::KIND_WOKEN)))
    else $error("A wakeup burst broke off before its final result.");

  a_answer_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != stq_pkg::KIND_WOKEN)) |-> out_last)
    else $error("A sleep answer was not marked as the final result.");

endmodule

bind sleep_wakeup_timer_queue_core stq_props u_stq_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_last        (out_last)
);

`default_nettype wire
